// ----- src/fit_policy_segment_allocator_assert.svh -----
// Assertion macros for the segment allocator.
`ifndef FIT_POLICY_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_SEGMENT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FPSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/fpsa_pkg.sv -----
// Shared types and constants for the segment allocator.
package fpsa_pkg;

	localparam int SIZE_W   = 21;
	localparam int REQ_W    = 16;
	localparam int OWNIN_W  = 8;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_ALLOC  = 2'd1;
	localparam logic [1:0] MODE_FREE   = 2'd2;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_NOOWNER = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic [2:0] OP_HOLD   = 3'd0;
	localparam logic [2:0] OP_ROT    = 3'd1;
	localparam logic [2:0] OP_APPEND = 3'd2;
	localparam logic [2:0] OP_GRANT  = 3'd3;
	localparam logic [2:0] OP_MERGE  = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic       split;
	} cmd_t;

endpackage

// ----- src/fit_policy_segment_allocator.sv -----
// Top level: first/best/worst fit segment allocator over a ring of slot cells.
//  channel | dir | tdata (low bit up)                                 | tuser
//  s_axis  | in  | req_size[15:0] owner_id[23:16] fit_policy[25:24]   | mode[1:0]
//  m_axis  | out | alloc_offset[20:0]                                 | status[1:0]
// Append adds one segment at the end of the table unless it is full. Allocate scans
// while the table rotates once through the cell ring, then grants. Free scans the same
// way, then merges one free pair at a time. One word in work at a time.
// arst_n clears control state and the segment count; slot contents need no reset.
// A result waits in the output register while m_axis_tready is low.
module fit_policy_segment_allocator #(
	parameter int MAX_SEGMENTS = 32,
	parameter int OWNER_BITS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // req_size, owner_id, fit_policy
	input  logic [1:0]  s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // alloc_offset
	output logic [1:0]  m_axis_tuser   // status
);
	import fpsa_pkg::*;

	localparam int N     = MAX_SEGMENTS;
	localparam int POS_W = $clog2(N);
	localparam int CNT_W = $clog2(N + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_APPEND = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_GRANT  = 3'd3;
	localparam logic [2:0] S_MERGE  = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [POS_W-1:0]      k_q;
	logic [1:0]            mode_q;
	logic [REQ_W-1:0]      req_q;
	logic [OWNER_BITS-1:0] own_q;
	logic [1:0]            pol_q;
	logic                  found_q;
	logic [POS_W-1:0]      sel_q;
	logic [SIZE_W-1:0]     selsz_q;
	logic [SIZE_W-1:0]     seloff_q;
	logic [SIZE_W-1:0]     off_q;
	logic [1:0]            st_q;
	logic [SIZE_W-1:0]     res_off_q;
	logic                  out_valid_q;
	logic [1:0]            out_st_q;
	logic [SIZE_W-1:0]     out_off_q;

	cmd_t                  cmd;
	logic [POS_W-1:0]      pos;
	logic [SIZE_W-1:0]     a_size, b_size, t_size;
	logic                  a_free, t_free;
	logic [OWNER_BITS-1:0] a_owner, t_owner;

	logic [SIZE_W-1:0]     c_size  [N];
	logic                  c_free  [N];
	logic [OWNER_BITS-1:0] c_owner [N];

	logic                  h_valid, fit, take, split;
	logic [SIZE_W-1:0]     req_ext;
	logic                  any_pair;
	logic [POS_W-1:0]      pair_pos;
	logic                  accept;
	logic                  grant_full;
	logic                  resp_fire;
	logic                  merge_step;

	assign req_ext = SIZE_W'(req_q);
	assign h_valid = CNT_W'(k_q) < cnt_q;
	assign fit     = h_valid && c_free[0] && (c_size[0] >= req_ext);
	assign split   = selsz_q > req_ext;
	assign grant_full = split && (cnt_q >= CNT_W'(N));
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign resp_fire  = (state_q == S_RESP) && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (state_q == S_IDLE);

	always_comb begin
		case (pol_q)
			POL_FIRST: take = fit && !found_q;
			POL_BEST:  take = fit && (!found_q || c_size[0] < selsz_q);
			POL_WORST: take = fit && (!found_q || c_size[0] > selsz_q);
			default:   take = 1'b0;
		endcase
	end

	logic match;
	assign match = (mode_q == MODE_FREE) && h_valid && (st_q == ST_NOOWNER)
		&& !c_free[0] && (c_owner[0] == own_q);

	always_comb begin
		any_pair = 1'b0;
		pair_pos = '0;
		for (int i = N - 1; i >= 1; i--) begin
			if (i < int'(cnt_q) && c_free[i] && c_free[i-1]) begin
				any_pair = 1'b1;
				pair_pos = POS_W'(i);
			end
		end
	end

	assign merge_step = (state_q == S_MERGE) && any_pair;

	always_comb begin
		cmd.op    = OP_HOLD;
		cmd.split = 1'b0;
		pos       = '0;
		a_size    = req_ext;
		a_free    = 1'b0;
		a_owner   = own_q;
		b_size    = selsz_q - req_ext;
		t_size    = c_size[0];
		t_free    = c_free[0];
		t_owner   = c_owner[0];
		case (state_q)
			S_APPEND: begin
				if (cnt_q < CNT_W'(N)) begin
					cmd.op  = OP_APPEND;
					pos     = cnt_q[POS_W-1:0];
					a_free  = 1'b1;
					a_owner = '0;
				end
			end
			S_SCAN: begin
				cmd.op = OP_ROT;
				if (match) begin
					t_free  = 1'b1;
					t_owner = '0;
				end
			end
			S_GRANT: begin
				if (!grant_full) begin
					cmd.op    = OP_GRANT;
					cmd.split = split;
					pos       = sel_q;
				end
			end
			S_MERGE: begin
				if (any_pair) begin
					cmd.op = OP_MERGE;
					pos    = pair_pos;
				end
			end
			default: ;
		endcase
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [SIZE_W-1:0]     n_size, p_size;
		logic                  n_free, p_free;
		logic [OWNER_BITS-1:0] n_owner, p_owner;
		if (g == N - 1) begin : g_last
			assign n_size  = t_size;
			assign n_free  = t_free;
			assign n_owner = t_owner;
		end else begin : g_mid
			assign n_size  = c_size[g+1];
			assign n_free  = c_free[g+1];
			assign n_owner = c_owner[g+1];
		end
		if (g == 0) begin : g_first
			assign p_size  = '0;
			assign p_free  = 1'b0;
			assign p_owner = '0;
		end else begin : g_rest
			assign p_size  = c_size[g-1];
			assign p_free  = c_free[g-1];
			assign p_owner = c_owner[g-1];
		end
		fpsa_cell #(
			.IDX(g), .OWNER_BITS(OWNER_BITS), .POS_W(POS_W)
		) u_cell (
			.clk(clk), .cmd(cmd), .pos(pos),
			.nxt_size(n_size), .nxt_free(n_free), .nxt_owner(n_owner),
			.prv_size(p_size), .prv_free(p_free), .prv_owner(p_owner),
			.a_size(a_size), .a_free(a_free), .a_owner(a_owner), .b_size(b_size),
			.size(c_size[g]), .free(c_free[g]), .owner(c_owner[g])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_axis_tuser;
			req_q  <= s_axis_tdata[15:0];
			own_q  <= OWNER_BITS'(s_axis_tdata[23:16]);
			pol_q  <= s_axis_tdata[25:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			found_q     <= 1'b0;
			sel_q       <= '0;
			selsz_q     <= '0;
			seloff_q    <= '0;
			off_q       <= '0;
			st_q        <= ST_OK;
			res_off_q   <= '0;
			out_valid_q <= 1'b0;
			out_st_q    <= ST_OK;
			out_off_q   <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && !resp_fire) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q       <= '0;
						found_q   <= 1'b0;
						off_q     <= '0;
						res_off_q <= '0;
						st_q      <= (s_axis_tuser == MODE_FREE) ? ST_NOOWNER : ST_OK;
						case (s_axis_tuser)
							MODE_APPEND: state_q <= S_APPEND;
							MODE_ALLOC:  state_q <= S_SCAN;
							MODE_FREE:   state_q <= S_SCAN;
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_APPEND: begin
					if (cnt_q < CNT_W'(N)) cnt_q <= cnt_q + 1'b1;
					else st_q <= ST_FULL;
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (h_valid) off_q <= off_q + c_size[0];
					if (mode_q == MODE_ALLOC && take) begin
						found_q  <= 1'b1;
						sel_q    <= k_q;
						selsz_q  <= c_size[0];
						seloff_q <= off_q;
					end
					if (match) st_q <= ST_OK;
					if (k_q == POS_W'(N - 1)) begin
						k_q <= '0;
						if (mode_q == MODE_FREE) begin
							state_q <= S_MERGE;
						end else if (!(found_q || take)) begin
							st_q    <= ST_NOFIT;
							state_q <= S_RESP;
						end else begin
							state_q <= S_GRANT;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_GRANT: begin
					if (grant_full) begin
						st_q <= ST_FULL;
					end else begin
						if (split) cnt_q <= cnt_q + 1'b1;
						res_off_q <= seloff_q;
					end
					state_q <= S_RESP;
				end
				S_MERGE: begin
					if (any_pair) cnt_q <= cnt_q - 1'b1;
					else state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_fire) begin
						out_valid_q <= 1'b1;
						out_st_q    <= st_q;
						out_off_q   <= res_off_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_off_q};
	assign m_axis_tuser  = out_st_q;

	`include "fit_policy_segment_allocator_assert.svh"

	`FPSA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_W'(N), "segment count above table size")
	`FPSA_ASSERT_NXT(a_merge_dec, merge_step, cnt_q == $past(cnt_q) - 1'b1, "merge kept count")
	`FPSA_ASSERT_NXT(a_resp_out, resp_fire, out_valid_q && state_q == S_IDLE, "result not posted")
	`FPSA_ASSERT_IMP(a_grant_ok, state_q == S_GRANT, found_q, "grant without selected segment")

endmodule

// ----- src/fpsa_cell.sv -----
// One table slot: holds a segment and moves it to or from its neighbors.
module fpsa_cell #(
	parameter int IDX        = 0,
	parameter int OWNER_BITS = 8,
	parameter int POS_W      = 5
) (
	input  logic                     clk,
	input  fpsa_pkg::cmd_t           cmd,
	input  logic [POS_W-1:0]         pos,
	input  logic [fpsa_pkg::SIZE_W-1:0] nxt_size,
	input  logic                     nxt_free,
	input  logic [OWNER_BITS-1:0]    nxt_owner,
	input  logic [fpsa_pkg::SIZE_W-1:0] prv_size,
	input  logic                     prv_free,
	input  logic [OWNER_BITS-1:0]    prv_owner,
	input  logic [fpsa_pkg::SIZE_W-1:0] a_size,
	input  logic                     a_free,
	input  logic [OWNER_BITS-1:0]    a_owner,
	input  logic [fpsa_pkg::SIZE_W-1:0] b_size,
	output logic [fpsa_pkg::SIZE_W-1:0] size,
	output logic                     free,
	output logic [OWNER_BITS-1:0]    owner
);
	import fpsa_pkg::*;

	logic [SIZE_W-1:0]     size_q;
	logic                  free_q;
	logic [OWNER_BITS-1:0] owner_q;
	int                    p;

	assign p = int'(pos);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ROT: begin
				size_q  <= nxt_size;
				free_q  <= nxt_free;
				owner_q <= nxt_owner;
			end
			OP_APPEND: begin
				if (IDX == p) begin
					size_q  <= a_size;
					free_q  <= a_free;
					owner_q <= a_owner;
				end
			end
			OP_GRANT: begin
				if (IDX == p) begin
					size_q  <= a_size;
					free_q  <= a_free;
					owner_q <= a_owner;
				end else if (cmd.split && IDX == p + 1) begin
					size_q  <= b_size;
					free_q  <= 1'b1;
					owner_q <= '0;
				end else if (cmd.split && IDX > p + 1) begin
					size_q  <= prv_size;
					free_q  <= prv_free;
					owner_q <= prv_owner;
				end
			end
			OP_MERGE: begin
				if (IDX + 1 == p) begin
					size_q <= size_q + nxt_size;
				end else if (IDX >= p) begin
					size_q  <= nxt_size;
					free_q  <= nxt_free;
					owner_q <= nxt_owner;
				end
			end
			default: ;
		endcase
	end

	assign size  = size_q;
	assign free  = free_q;
	assign owner = owner_q;

endmodule

// ----- bench/fit_policy_segment_allocator_tb.sv -----
// Testbench for the fit-policy segment allocator: scoreboard predictor, random stimulus, stalls.
module fit_policy_segment_allocator_tb;
	import fpsa_pkg::*;

	localparam int NSEG = 32;
	localparam int OWNER_W = 8;

	typedef struct packed {
		logic [1:0]        status;
		logic [SIZE_W-1:0] offset;
	} grant_t;

	class segment_table_board;
		logic [SIZE_W-1:0]  size_q[NSEG];
		bit                 free_q[NSEG];
		logic [OWNER_W-1:0] owner_q[NSEG];
		int                 count;
		grant_t             pending[$];
		int                 errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		function void merge_runs();
			int w;
			w = 0;
			for (int r = 0; r < count; r++) begin
				if (w > 0 && free_q[w-1] && free_q[r]) begin
					size_q[w-1] = size_q[w-1] + size_q[r];
				end else begin
					size_q[w] = size_q[r];
					free_q[w] = free_q[r];
					owner_q[w] = owner_q[r];
					w++;
				end
			end
			count = w;
		endfunction

		function grant_t grant(logic [SIZE_W-1:0] req, logic [OWNER_W-1:0] own,
				logic [1:0] pol);
			grant_t g;
			bit found;
			int sel;
			found = 0;
			sel = 0;
			g = '0;
			for (int i = 0; i < count; i++) begin
				if (!free_q[i] || size_q[i] < req) continue;
				if (pol == POL_FIRST) begin
					if (!found) begin
						found = 1;
						sel = i;
					end
				end else if (pol == POL_BEST) begin
					if (!found || size_q[i] < size_q[sel]) begin
						found = 1;
						sel = i;
					end
				end else if (pol == POL_WORST) begin
					if (!found || size_q[i] > size_q[sel]) begin
						found = 1;
						sel = i;
					end
				end
			end
			if (!found) begin
				g.status = ST_NOFIT;
				return g;
			end
			if (size_q[sel] > req) begin
				if (count >= NSEG) begin
					g.status = ST_FULL;
					return g;
				end
				for (int i = count; i > sel + 1; i--) begin
					size_q[i] = size_q[i-1];
					free_q[i] = free_q[i-1];
					owner_q[i] = owner_q[i-1];
				end
				size_q[sel+1] = size_q[sel] - req;
				free_q[sel+1] = 1;
				owner_q[sel+1] = '0;
				count++;
				size_q[sel] = req;
			end
			free_q[sel] = 0;
			owner_q[sel] = own;
			g.status = ST_OK;
			for (int i = 0; i < sel; i++) g.offset = g.offset + size_q[i];
			return g;
		endfunction

		function void note_request(logic [1:0] mode, logic [15:0] req,
				logic [7:0] own, logic [1:0] pol);
			grant_t g;
			g = '0;
			if (mode == MODE_APPEND) begin
				if (count >= NSEG) g.status = ST_FULL;
				else begin
					size_q[count] = SIZE_W'(req);
					free_q[count] = 1;
					owner_q[count] = '0;
					count++;
				end
			end else if (mode == MODE_ALLOC) begin
				g = grant(SIZE_W'(req), own, pol);
			end else if (mode == MODE_FREE) begin
				g.status = ST_NOOWNER;
				for (int i = 0; i < count; i++) begin
					if (!free_q[i] && owner_q[i] == own) begin
						free_q[i] = 1;
						owner_q[i] = '0;
						g.status = ST_OK;
						break;
					end
				end
				merge_runs();
			end
			pending.push_back(g);
		endfunction

		task automatic report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task automatic check_result(logic [1:0] st, logic [23:0] data);
			grant_t g;
			if (pending.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			g = pending.pop_front();
			if (st !== g.status)
				report($sformatf("status %0d, expected %0d", st, g.status));
			if (data !== {3'b0, g.offset})
				report($sformatf("offset %0d, expected %0d", data, g.offset));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	segment_table_board board;
	bit sink_hold;
	bit stim_done;

	fit_policy_segment_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	task automatic send_word(logic [1:0] mode, logic [15:0] req, logic [7:0] own,
			logic [1:0] pol, bit may_idle);
		int g;
		g = may_idle ? gap_len() : 0;
		repeat (g) @(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tuser = mode;
		s_axis_tdata = {6'b0, pol, own, req};
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(mode, req, own, pol);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return 16'($urandom_range(0, 64));
		if (r < 8) return 16'($urandom_range(0, 4096));
		return 16'($urandom());
	endfunction

	function automatic logic [7:0] rand_owner();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
			: 8'($urandom_range(1, 6));
	endfunction

	// receiver
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tuser, m_axis_tdata);
	end

	initial begin
		int g;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold) m_axis_tready <= 0;
			else if (stim_done) m_axis_tready <= 1;
			else begin
				g = $urandom_range(0, 99);
				if (g >= 98) begin
					m_axis_tready <= 0;
					repeat ($urandom_range(10, 100)) @(negedge clk);
					m_axis_tready <= 1;
				end else begin
					m_axis_tready <= (g < 70);
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int n;
		board = new();
		sink_hold = 0;
		stim_done = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_APPEND;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed
		send_word(MODE_ALLOC, 16'd0, 8'd1, POL_FIRST, 0);
		send_word(MODE_FREE, 16'd0, 8'd9, POL_FIRST, 0);
		send_word(MODE_APPEND, 16'hFFFF, 8'd0, POL_FIRST, 0);
		send_word(MODE_APPEND, 16'd0, 8'd0, POL_FIRST, 0);
		send_word(MODE_APPEND, 16'd100, 8'd0, POL_FIRST, 0);
		send_word(MODE_APPEND, 16'd50, 8'd0, POL_FIRST, 0);
		send_word(MODE_ALLOC, 16'd40, 8'd255, POL_BEST, 0);
		send_word(MODE_ALLOC, 16'd40, 8'd2, POL_WORST, 0);
		send_word(MODE_ALLOC, 16'd1, 8'd3, POL_FIRST, 0);
		send_word(MODE_ALLOC, 16'd1, 8'd4, 2'd3, 0);
		send_word(MODE_ALLOC, 16'd0, 8'd5, POL_FIRST, 0);
		send_word(MODE_ALLOC, 16'hFFFF, 8'd6, POL_FIRST, 0);
		send_word(MODE_ALLOC, 16'd60000, 8'd6, POL_BEST, 0);
		send_word(2'd3, 16'hFFFF, 8'hFF, 2'd3, 0);
		send_word(MODE_FREE, 16'd0, 8'd255, POL_FIRST, 0);
		send_word(MODE_FREE, 16'd0, 8'd2, POL_FIRST, 0);
		send_word(MODE_FREE, 16'd0, 8'd77, POL_FIRST, 0);
		for (int i = 0; i < 30; i++)
			send_word(MODE_APPEND, 16'd3, 8'd0, POL_FIRST, 0);
		send_word(MODE_ALLOC, 16'd1, 8'd7, POL_FIRST, 0);
		send_word(MODE_FREE, 16'd0, 8'd3, POL_FIRST, 0);
		send_word(MODE_FREE, 16'd0, 8'd4, POL_FIRST, 0);

		// fill-up: receiver held while sender keeps offering
		sink_hold = 1;
		fork
			begin
				repeat (300) @(negedge clk);
				sink_hold = 0;
			end
			for (int i = 0; i < 6; i++)
				send_word(MODE_ALLOC, 16'($urandom_range(0, 3)), 8'd8, POL_WORST, 0);
		join
		drain();

		// random: mostly append/alloc/free sessions, table freed down regularly
		n = 0;
		while (n < 1300) begin
			int r;
			logic [1:0] m;
			r = $urandom_range(0, 99);
			if (r < 25) m = MODE_APPEND;
			else if (r < 60) m = MODE_ALLOC;
			else if (r < 97) m = MODE_FREE;
			else m = 2'd3;
			if (m != 2'd3) n++;
			send_word(m, rand_size(), rand_owner(), 2'($urandom_range(0, 3)), 1);
			if (n % 200 == 100) drain();
		end

		stim_done = 1;
		drain();
		repeat (200) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+src
src/fpsa_pkg.sv
src/fpsa_cell.sv
src/fit_policy_segment_allocator.sv
bench/fit_policy_segment_allocator_tb.sv
